// File: rtl/triangle_edge_classify_macros.svh
// ----------------------------------------------------------------------------
// Triangle edge classifier: assertion macros
// Concurrent assertion shorthands clocked on clk_i, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_EDGE_CLASSIFY_MACROS_SVH
`define TRIANGLE_EDGE_CLASSIFY_MACROS_SVH

// plain property
`define TEC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define TEC_ASSERT_IMP(name, ante, cons, msg) \
  `TEC_ASSERT(name, (ante) |-> (cons), msg)

// next-cycle implication
`define TEC_ASSERT_NXT(name, ante, cons, msg) \
  `TEC_ASSERT(name, (ante) |=> (cons), msg)

`endif

// File: rtl/tec_pkg.sv
// ----------------------------------------------------------------------------
// Triangle edge classifier: package
// Widths, payload types, register indexes and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tec_pkg;

  // output coordinate width and fixed-point split
  localparam int COORD_WIDTH = 16;
  localparam int FRAC_BITS   = 12;
  localparam int QB          = COORD_WIDTH - 1;   // quotient bits, one per divider stage

  // datapath widths
  localparam int IN_W  = 16;                      // Q7.8 coordinate
  localparam int REG_W = 48;                      // packed x,y,z register
  localparam int DIF_W = IN_W + 1;                // difference of two coordinates
  localparam int CRS_W = 2 * DIF_W;               // cross-product component
  localparam int PRD_W = DIF_W + CRS_W;           // one term of a dot product
  localparam int DET_W = PRD_W + 2;               // 3x3 determinant
  localparam int REM_W = DET_W + QB + 1;          // divider remainder

  // saturation: |q| >= 2^(COORD_WIDTH-13) in integer units
  localparam bit SAT_ALWAYS = (COORD_WIDTH < FRAC_BITS + 1);
  localparam int SAT_SH     = SAT_ALWAYS ? 0 : COORD_WIDTH - FRAC_BITS - 1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_VERTEX_ZERO = 2'd0,
    REG_VERTEX_ONE  = 2'd1,
    REG_VERTEX_TWO  = 2'd2,
    REG_FACE_NORMAL = 2'd3
  } cfg_reg_e;

  // exit edge codes
  localparam logic [1:0] EXIT_EDGE0 = 2'd0;   // also inside
  localparam logic [1:0] EXIT_EDGE1 = 2'd1;
  localparam logic [1:0] EXIT_EDGE2 = 2'd2;

  // edge flag bit positions
  localparam int FLAG_B_NEG   = 0;
  localparam int FLAG_AB_OVER = 1;
  localparam int FLAG_A_NEG   = 2;

  typedef struct packed {
    logic signed [IN_W-1:0] point_x;
    logic signed [IN_W-1:0] point_y;
    logic signed [IN_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] coord_a;
    logic signed [COORD_WIDTH-1:0] coord_b;
    logic signed [COORD_WIDTH-1:0] coord_c;
    logic        [2:0]             edge_flags;
    logic        [1:0]             exit_edge;
    logic                          singular;
  } result_t;

  // classification that rides alongside the divider
  typedef struct packed {
    logic       sing;
    logic [2:0] neg;       // a, b, c sign
    logic [2:0] sat;       // a, b, c saturate
    logic [2:0] flags;
    logic [1:0] exit_sel;
  } side_t;

  typedef struct packed {
    logic signed [DIF_W-1:0] x;
    logic signed [DIF_W-1:0] y;
    logic signed [DIF_W-1:0] z;
  } dvec_t;

  typedef struct packed {
    logic signed [CRS_W-1:0] x;
    logic signed [CRS_W-1:0] y;
    logic signed [CRS_W-1:0] z;
  } cvec_t;

  typedef struct packed {
    logic signed [PRD_W-1:0] x;
    logic signed [PRD_W-1:0] y;
    logic signed [PRD_W-1:0] z;
  } pvec_t;

endpackage

`default_nettype wire

// File: rtl/tec_if.sv
// ----------------------------------------------------------------------------
// Triangle edge classifier: stream interfaces
// Valid/ready channels for input points and classification results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tec_point_if import tec_pkg::*; ();
  logic   valid;
  logic   ready;
  point_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tec_result_if import tec_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/tec_div_pipe.sv
// ----------------------------------------------------------------------------
// Triangle edge classifier: pipelined divider
// Restoring division of (num << FRAC_BITS) by den, one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tec_div_pipe import tec_pkg::*; (
  input  logic             clk_i,
  input  logic [QB-1:0]    en_i,     // per-stage load enable
  input  logic [DET_W-1:0] num_i,    // magnitude
  input  logic [DET_W-1:0] den_i,    // positive divisor
  output logic [QB-1:0]    quo_o
);

  logic [REM_W-1:0] rem_q [QB];
  logic [DET_W-1:0] dsr_q [QB];
  logic [QB-1:0]    quo_q [QB];

  for (genvar s = 0; s < QB; s++) begin : g_step
    localparam int J = QB - 1 - s;   // quotient bit settled here

    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] cand;
    logic [DET_W-1:0] dsr_in;
    logic [QB-1:0]    quo_in;

    if (s == 0) begin : g_first
      assign rem_in = REM_W'(num_i) << FRAC_BITS;
      assign dsr_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign dsr_in = dsr_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign cand = REM_W'(dsr_in) << J;

    // compare, subtract, set bit
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        dsr_q[s] <= dsr_in;
        if (rem_in >= cand) begin
          rem_q[s] <= rem_in - cand;
          quo_q[s] <= quo_in | (QB'(1) << J);
        end else begin
          rem_q[s] <= rem_in;
          quo_q[s] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

`default_nettype wire

// File: rtl/triangle_edge_classify.sv
// ----------------------------------------------------------------------------
// Triangle edge classifier: top level
// Solves a*(v1-v0) + b*(v2-v0) + c*n = p-v0 by Cramer's rule per point and
// reports saturated Q3.12 weights, edge flags and a priority exit edge.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          beat
//  pt_i      in   valid/ready        point_x, point_y, point_z (Q7.8)
//  res_o     out  valid/ready        coord_a/b/c, edge_flags, exit_edge, singular
//  cfg       in   cfg_we_i           cfg_idx_i selects register, cfg_data_i
//
//  One beat a cycle sustained while res_o is ready; the QB-stage restoring
//  divider follows the solve and feeds the output register.
//  Reset clears the triangle registers and all stage valid bits.
//  Triangle cross products, then dp_q, then the determinant register after a write.
//  Each stage loads when it is empty or the next one loads; a stalled
//  result holds in the output register while bubbles ahead of it fill.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_edge_classify import tec_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  cfg_reg_e           cfg_idx_i,
  input  logic [REG_W-1:0]   cfg_data_i,
  tec_point_if.sink          pt_i,
  tec_result_if.source       res_o
);

  localparam int DIV0 = 5;            // first divider stage
  localparam int OUTS = DIV0 + QB;    // output register stage
  localparam int NST  = OUTS + 1;

  function automatic dvec_t unpack_vec(input logic [REG_W-1:0] r);
    dvec_t v;
    v.x = DIF_W'($signed(r[47:32]));
    v.y = DIF_W'($signed(r[31:16]));
    v.z = DIF_W'($signed(r[15:0]));
    return v;
  endfunction

  function automatic dvec_t sub_vec(input dvec_t u, input dvec_t v);
    dvec_t r;
    r.x = u.x - v.x;
    r.y = u.y - v.y;
    r.z = u.z - v.z;
    return r;
  endfunction

  function automatic cvec_t cross_vec(input dvec_t u, input dvec_t v);
    cvec_t r;
    r.x = CRS_W'(u.y) * CRS_W'(v.z) - CRS_W'(u.z) * CRS_W'(v.y);
    r.y = CRS_W'(u.z) * CRS_W'(v.x) - CRS_W'(u.x) * CRS_W'(v.z);
    r.z = CRS_W'(u.x) * CRS_W'(v.y) - CRS_W'(u.y) * CRS_W'(v.x);
    return r;
  endfunction

  function automatic pvec_t mul_vec(input dvec_t u, input cvec_t v);
    pvec_t r;
    r.x = PRD_W'(u.x) * PRD_W'(v.x);
    r.y = PRD_W'(u.y) * PRD_W'(v.y);
    r.z = PRD_W'(u.z) * PRD_W'(v.z);
    return r;
  endfunction

  function automatic logic signed [DET_W-1:0] sum_vec(input pvec_t p);
    return DET_W'(p.x) + DET_W'(p.y) + DET_W'(p.z);
  endfunction

  // --------------------------------------------------------------------------
  // triangle registers
  // --------------------------------------------------------------------------
  logic [REG_W-1:0] v0_q, v1_q, v2_q, nrm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= '0;
      v1_q  <= '0;
      v2_q  <= '0;
      nrm_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VERTEX_ZERO: v0_q  <= cfg_data_i;
        REG_VERTEX_ONE:  v1_q  <= cfg_data_i;
        REG_VERTEX_TWO:  v2_q  <= cfg_data_i;
        REG_FACE_NORMAL: nrm_q <= cfg_data_i;
        default:         v0_q  <= v0_q;
      endcase
    end
  end

  // triangle-only terms: cross products, then system determinant
  dvec_t e1, e2, nv, v0v;
  cvec_t a_q, b_q, c_q;
  pvec_t dp_q;
  logic signed [DET_W-1:0] den_q;

  assign v0v = unpack_vec(v0_q);
  assign nv  = unpack_vec(nrm_q);
  assign e1  = sub_vec(unpack_vec(v1_q), v0v);
  assign e2  = sub_vec(unpack_vec(v2_q), v0v);

  always_ff @(posedge clk_i) begin
    a_q   <= cross_vec(e2, nv);
    b_q   <= cross_vec(nv, e1);
    c_q   <= cross_vec(e1, e2);
    dp_q  <= mul_vec(e1, a_q);
    den_q <= sum_vec(dp_q);
  end

  // --------------------------------------------------------------------------
  // stage valids and load enables
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q, vld_d, en;

  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign en[NST-1] = !vld_q[NST-1] || res_o.ready;
  assign vld_d     = {vld_q[NST-2:0], pt_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  assign pt_i.ready = en[0];

  // --------------------------------------------------------------------------
  // stage 0: d = p - v0
  // --------------------------------------------------------------------------
  dvec_t pv, d_q;

  assign pv.x = DIF_W'(pt_i.data.point_x);
  assign pv.y = DIF_W'(pt_i.data.point_y);
  assign pv.z = DIF_W'(pt_i.data.point_z);

  always_ff @(posedge clk_i) begin
    if (en[0]) d_q <= sub_vec(pv, v0v);
  end

  // stage 1: dot-product terms
  pvec_t pa_q, pb_q, pc_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pa_q <= mul_vec(d_q, a_q);
      pb_q <= mul_vec(d_q, b_q);
      pc_q <= mul_vec(d_q, c_q);
    end
  end

  // stage 2: numerators
  logic signed [DET_W-1:0] na_q, nb_q, nc_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      na_q <= sum_vec(pa_q);
      nb_q <= sum_vec(pb_q);
      nc_q <= sum_vec(pc_q);
    end
  end

  // stage 3: make the determinant positive
  logic signed [DET_W-1:0] sa_q, sb_q, sc_q, sd_q;
  logic                    sing_q;
  logic                    den_neg;

  assign den_neg = den_q[DET_W-1];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sa_q   <= den_neg ? -na_q  : na_q;
      sb_q   <= den_neg ? -nb_q  : nb_q;
      sc_q   <= den_neg ? -nc_q  : nc_q;
      sd_q   <= den_neg ? -den_q : den_q;
      sing_q <= (den_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: flags, exit edge, magnitudes, saturation
  // --------------------------------------------------------------------------
  side_t                   side_d;
  logic [DET_W-1:0]        ma_d, mb_d, mc_d;
  logic [DET_W-1:0]        ma_q, mb_q, mc_q, dv_q;
  logic signed [DET_W-1:0] ab_sum;

  always_comb begin
    ab_sum           = sa_q + sb_q;
    ma_d             = sa_q[DET_W-1] ? DET_W'(-sa_q) : DET_W'(sa_q);
    mb_d             = sb_q[DET_W-1] ? DET_W'(-sb_q) : DET_W'(sb_q);
    mc_d             = sc_q[DET_W-1] ? DET_W'(-sc_q) : DET_W'(sc_q);

    side_d.sing      = sing_q;
    side_d.neg       = {sc_q[DET_W-1], sb_q[DET_W-1], sa_q[DET_W-1]};
    side_d.sat[0]    = SAT_ALWAYS || (REM_W'(ma_d) >= (REM_W'(sd_q) << SAT_SH));
    side_d.sat[1]    = SAT_ALWAYS || (REM_W'(mb_d) >= (REM_W'(sd_q) << SAT_SH));
    side_d.sat[2]    = SAT_ALWAYS || (REM_W'(mc_d) >= (REM_W'(sd_q) << SAT_SH));

    side_d.flags                = '0;
    side_d.flags[FLAG_A_NEG]    = sa_q[DET_W-1];
    side_d.flags[FLAG_B_NEG]    = sb_q[DET_W-1];
    side_d.flags[FLAG_AB_OVER]  = (ab_sum > sd_q);

    // edge 2 first, then edge 0, then edge 1
    priority if (sa_q[DET_W-1] && (sa_q < sb_q) && (ab_sum + sa_q < sd_q)) begin
      side_d.exit_sel = EXIT_EDGE2;
    end else if (sb_q[DET_W-1] && (ab_sum + sb_q < sd_q)) begin
      side_d.exit_sel = EXIT_EDGE0;
    end else if (ab_sum > sd_q) begin
      side_d.exit_sel = EXIT_EDGE1;
    end else begin
      side_d.exit_sel = EXIT_EDGE0;
    end
  end

  side_t side_q [QB+1];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      ma_q      <= ma_d;
      mb_q      <= mb_d;
      mc_q      <= mc_d;
      dv_q      <= DET_W'(sd_q);
    end
  end

  // --------------------------------------------------------------------------
  // divider stages, classification rides alongside
  // --------------------------------------------------------------------------
  logic [QB-1:0] qa, qb, qc;

  tec_div_pipe u_div_a (.clk_i, .en_i(en[DIV0 +: QB]), .num_i(ma_q), .den_i(dv_q), .quo_o(qa));
  tec_div_pipe u_div_b (.clk_i, .en_i(en[DIV0 +: QB]), .num_i(mb_q), .den_i(dv_q), .quo_o(qb));
  tec_div_pipe u_div_c (.clk_i, .en_i(en[DIV0 +: QB]), .num_i(mc_q), .den_i(dv_q), .quo_o(qc));

  always_ff @(posedge clk_i) begin
    if (en[4]) side_q[0] <= side_d;
    for (int s = 0; s < QB; s++) begin
      if (en[DIV0+s]) side_q[s+1] <= side_q[s];
    end
  end

  // --------------------------------------------------------------------------
  // output register: sign, saturate, singular override
  // --------------------------------------------------------------------------
  function automatic logic [COORD_WIDTH-1:0] fix_coord(input logic neg, input logic sat,
                                                       input logic [QB-1:0] q);
    logic [COORD_WIDTH-1:0] mag;
    mag = {1'b0, q};
    if (sat) return neg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
    return neg ? -mag : mag;
  endfunction

  side_t   sd_out;
  result_t res_d, res_q;

  assign sd_out = side_q[QB];

  always_comb begin
    if (sd_out.sing) begin
      res_d          = '0;
      res_d.singular = 1'b1;
    end else begin
      res_d.coord_a    = fix_coord(sd_out.neg[0], sd_out.sat[0], qa);
      res_d.coord_b    = fix_coord(sd_out.neg[1], sd_out.sat[1], qb);
      res_d.coord_c    = fix_coord(sd_out.neg[2], sd_out.sat[2], qc);
      res_d.edge_flags = sd_out.flags;
      res_d.exit_edge  = sd_out.exit_sel;
      res_d.singular   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUTS]) res_q <= res_d;
  end

  assign res_o.valid = vld_q[OUTS];
  assign res_o.data  = res_q;

endmodule

`default_nettype wire

// File: rtl/tec_checker.sv
// ----------------------------------------------------------------------------
// Triangle edge classifier: result checker
// Port-level checks on result beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_edge_classify_macros.svh"

module tec_checker import tec_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    valid_i,
  input logic    ready_i,
  input result_t data_i
);

  logic stalled, sing_clean, exit_ok, a_sign_ok;

  assign stalled    = valid_i && !ready_i;
  assign sing_clean = data_i.coord_a == '0 && data_i.coord_b == '0
                      && data_i.coord_c == '0 && data_i.edge_flags == '0
                      && data_i.exit_edge == EXIT_EDGE0;
  assign exit_ok    = (data_i.exit_edge != EXIT_EDGE2 || data_i.edge_flags[FLAG_A_NEG])
                      && (data_i.exit_edge != EXIT_EDGE1 || data_i.edge_flags[FLAG_AB_OVER]);
  assign a_sign_ok  = data_i.coord_a[COORD_WIDTH-1] || data_i.coord_a == '0;

  // stalled beat stays put
  `TEC_ASSERT_NXT(a_res_hold, stalled, valid_i && $stable(data_i), "result changed while stalled")

  // singular beats carry nothing else
  `TEC_ASSERT_IMP(a_sing_zero, valid_i && data_i.singular, sing_clean, "singular beat with data")

  // chosen exit edge agrees with its flag
  `TEC_ASSERT_IMP(a_exit_flag, valid_i, exit_ok, "exit edge without its flag")

  // a<0 never shows as a positive weight
  `TEC_ASSERT_IMP(a_sign_a, valid_i && data_i.edge_flags[FLAG_A_NEG], a_sign_ok, "coord_a sign")

endmodule

bind triangle_edge_classify tec_checker u_tec_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .valid_i (res_o.valid),
  .ready_i (res_o.ready),
  .data_i  (res_o.data)
);

`default_nettype wire

// File: dv/triangle_edge_classify_tb.sv
// ----------------------------------------------------------------------------
// Triangle edge classifier: testbench
// Loads a series of triangles, from well-shaped to degenerate and extreme,
// streams points at each one with random bursts and output stalls, and checks
// every result beat against a predictor that does its own exact Cramer solve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_edge_classify_tb;
  import tec_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int HOLD_CYCLES    = 300;
  localparam logic [15:0] ONE_Q78 = 16'sd256;

  // scoreboard: keeps its own triangle copy and the queue of expected beats
  class tri_scoreboard;
    typedef struct {longint x, y, z;} vec_t;

    logic [REG_W-1:0] tri_regs[4];
    result_t          expected_q[$];
    int               errors, points_seen, results_seen, singular_seen, outside_seen;

    function new();
      foreach (tri_regs[i]) tri_regs[i] = '0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [REG_W-1:0] value);
      tri_regs[idx] = value;
    endfunction

    function vec_t unpack(logic [REG_W-1:0] r);
      vec_t v;
      v.x = longint'(signed'(r[47:32]));
      v.y = longint'(signed'(r[31:16]));
      v.z = longint'(signed'(r[15:0]));
      return v;
    endfunction

    function vec_t diff(vec_t p, vec_t q);
      vec_t v;
      v.x = p.x - q.x;
      v.y = p.y - q.y;
      v.z = p.z - q.z;
      return v;
    endfunction

    // determinant with columns c0, c1, c2
    function longint det3(vec_t c0, vec_t c1, vec_t c2);
      return c0.x * (c1.y * c2.z - c1.z * c2.y)
           - c0.y * (c1.x * c2.z - c1.z * c2.x)
           + c0.z * (c1.x * c2.y - c1.y * c2.x);
    endfunction

    // num/den, den > 0, truncated toward zero to Q3.12, saturated
    function logic [COORD_WIDTH-1:0] to_fixed(longint num, longint den);
      bit        neg;
      bit [127:0] mag, q;
      neg = num < 0;
      mag = neg ? 128'(-num) : 128'(num);
      q   = (mag << FRAC_BITS) / 128'(den);
      if (q >= (128'd1 << (COORD_WIDTH - 1)))
        return neg ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      return neg ? -q[COORD_WIDTH-1:0] : q[COORD_WIDTH-1:0];
    endfunction

    function void note_point(point_t p);
      vec_t    v0, nrm, e1, e2, pt, d;
      longint  den, na, nb, nc;
      result_t w;
      v0  = unpack(tri_regs[REG_VERTEX_ZERO]);
      nrm = unpack(tri_regs[REG_FACE_NORMAL]);
      e1  = diff(unpack(tri_regs[REG_VERTEX_ONE]), v0);
      e2  = diff(unpack(tri_regs[REG_VERTEX_TWO]), v0);
      pt.x = longint'(p.point_x);
      pt.y = longint'(p.point_y);
      pt.z = longint'(p.point_z);
      d   = diff(pt, v0);
      w   = '0;
      points_seen++;
      den = det3(e1, e2, nrm);
      if (den == 0) begin
        w.singular = 1'b1;
        singular_seen++;
      end else begin
        na = det3(d, e2, nrm);
        nb = det3(e1, d, nrm);
        nc = det3(e1, e2, d);
        if (den < 0) begin
          den = -den; na = -na; nb = -nb; nc = -nc;
        end
        // exit priority: edge 2, then edge 0, then edge 1
        if (na < 0 && na < nb && 2 * na + nb < den) w.exit_edge = EXIT_EDGE2;
        else if (nb < 0 && na + 2 * nb < den)       w.exit_edge = EXIT_EDGE0;
        else if (na + nb > den)                     w.exit_edge = EXIT_EDGE1;
        else                                        w.exit_edge = EXIT_EDGE0;
        w.edge_flags[FLAG_A_NEG]   = na < 0;
        w.edge_flags[FLAG_B_NEG]   = nb < 0;
        w.edge_flags[FLAG_AB_OVER] = na + nb > den;
        if (w.edge_flags != 0) outside_seen++;
        w.coord_a = to_fixed(na, den);
        w.coord_b = to_fixed(nb, den);
        w.coord_c = to_fixed(nc, den);
      end
      expected_q.push_back(w);
    endfunction

    function void field_cmp(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t w;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result beat, expected none actual %h", $time, got);
        return;
      end
      w = expected_q.pop_front();
      field_cmp("coord_a",    w.coord_a,    got.coord_a);
      field_cmp("coord_b",    w.coord_b,    got.coord_b);
      field_cmp("coord_c",    w.coord_c,    got.coord_c);
      field_cmp("edge_flags", w.edge_flags, got.edge_flags);
      field_cmp("exit_edge",  w.exit_edge,  got.exit_edge);
      field_cmp("singular",   w.singular,   got.singular);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  cfg_reg_e         cfg_idx_i;
  logic [REG_W-1:0] cfg_data_i;

  tec_point_if  pt();
  tec_result_if res();

  triangle_edge_classify dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pt_i       (pt.sink),
    .res_o      (res.source)
  );

  tri_scoreboard sb = new();
  int  hold_req;
  bit  beat_seen;
  int  idle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // monitor at mid-cycle: handshake signals are settled for the next edge
  always @(negedge clk_i) begin
    beat_seen <= rst_ni && ((pt.valid && pt.ready) || (res.valid && res.ready));
    if (rst_ni && pt.valid && pt.ready) begin
      sb.note_point(pt.data);
    end
    if (rst_ni && res.valid && res.ready) begin
      sb.check_result(res.data);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (beat_seen) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("triangle_edge_classify verification failed");
      $finish;
    end
  end

  // receiver: stretches of different stall densities, plus a requested hold-off
  initial begin
    int mode, len, n;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        res.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
        hold_req = 0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = $urandom_range(5, 60);
        repeat (len) begin
          @(posedge clk_i);
          unique case (mode)
            0: res.ready <= 1'b1;
            1: res.ready <= ($urandom_range(0, 3) != 0);
            2: res.ready <= 1'($urandom_range(0, 1));
            default: res.ready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  function automatic logic [REG_W-1:0] pack(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    return {x, y, z};
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [REG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // block is idle here; give the triangle terms time to settle
  task automatic load_triangle(logic [REG_W-1:0] v0, logic [REG_W-1:0] v1,
                               logic [REG_W-1:0] v2, logic [REG_W-1:0] nrm);
    write_reg(REG_VERTEX_ZERO, v0);
    write_reg(REG_VERTEX_ONE,  v1);
    write_reg(REG_VERTEX_TWO,  v2);
    write_reg(REG_FACE_NORMAL, nrm);
    repeat (5) @(posedge clk_i);
  endtask

  // one point beat; valid stays high for back-to-back sends
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    pt.valid        <= 1'b1;
    pt.data.point_x <= x;
    pt.data.point_y <= y;
    pt.data.point_z <= z;
    @(negedge clk_i);
    while (!pt.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      pt.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    pt.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] near_coord(int span);
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // random points: mostly within +/-span of the origin, some anywhere in range
  task automatic random_points(int count, int span);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        if ($urandom_range(0, 3) == 0)
          send_point(16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_point(near_coord(span), near_coord(span), near_coord(span));
        sent++;
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
    end
  endtask

  initial begin
    int k;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = REG_VERTEX_ZERO;
    cfg_data_i = '0;
    pt.valid   = 1'b0;
    pt.data    = '0;
    hold_req   = 0;
    beat_seen  = 1'b0;
    idle_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset triangle is all zero: singular
    send_point(16'h0100, 16'h0000, 16'h0000);
    drain();

    // unit right triangle in the xy plane, normal along z
    load_triangle(pack(16'h0000, 16'h0000, 16'h0000), pack(ONE_Q78, 16'h0000, 16'h0000),
                  pack(16'h0000, ONE_Q78, 16'h0000), pack(16'h0000, 16'h0000, ONE_Q78));
    send_point(16'h0040, 16'h0040, 16'h0000);   // inside
    send_point(16'h0000, 16'h0000, 16'h0000);   // on vertex zero
    send_point(16'h0080, 16'h0080, 16'h0000);   // on hypotenuse, a+b == 1
    send_point(16'h0040, 16'hFFC0, 16'h0000);   // below: b < 0
    send_point(16'hFFC0, 16'h0040, 16'h0000);   // left: a < 0
    send_point(16'h00C0, 16'h00C0, 16'h0020);   // beyond hypotenuse
    send_point(16'hFF00, 16'hFF00, 16'h0000);   // a == b < 0 tie
    send_point(16'hFF00, 16'hFE00, 16'h0000);   // both negative, b lower
    send_point(16'h0200, 16'hFF00, 16'h0000);   // b < 0 and a+b == 1
    send_point(16'hFF00, 16'h0200, 16'h0000);   // a < 0 and a+b == 1
    send_point(16'h0055, 16'h0033, 16'h0011);   // inexact quotients
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);   // positive saturation
    send_point(16'h8000, 16'h8000, 16'h8000);   // negative saturation
    send_point(16'h07FF, 16'h0000, 16'hF801);   // just under the limit
    send_point(16'h0800, 16'h0000, 16'hF800);   // exactly at the limit
    send_point(16'h7FFF, 16'h8000, 16'h0000);
    send_point(16'hFFFF, 16'h0001, 16'hFFFF);
    drain();
    random_points(180, 400);

    // receiver holds off while points keep coming
    hold_req = HOLD_CYCLES;
    repeat (80) send_point(near_coord(300), near_coord(300), near_coord(300));
    drain();

    // mirrored winding, so the determinant is negative
    load_triangle(pack(16'h0100, 16'h0100, 16'h0000), pack(16'h0100, 16'h0300, 16'h0000),
                  pack(16'h0300, 16'h0100, 16'h0000), pack(16'h0000, 16'h0000, 16'h0400));
    random_points(180, 900);
    drain();

    // extreme coordinates
    load_triangle(pack(16'h8000, 16'h8000, 16'h8000), pack(16'h7FFF, 16'h8000, 16'h8000),
                  pack(16'h8000, 16'h7FFF, 16'h8000), pack(16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    random_points(150, 30000);
    drain();

    // degenerate: two vertices coincide
    load_triangle(pack(16'h0010, 16'h0020, 16'h0030), pack(16'h0400, 16'hFF00, 16'h0100),
                  pack(16'h0400, 16'hFF00, 16'h0100), pack(16'h0000, 16'h0100, 16'h0000));
    random_points(40, 2000);
    drain();

    // random triangles, small and full range
    for (k = 0; k < 6; k++) begin
      if (k % 2 == 0)
        load_triangle(pack(near_coord(600), near_coord(600), near_coord(600)),
                      pack(near_coord(600), near_coord(600), near_coord(600)),
                      pack(near_coord(600), near_coord(600), near_coord(600)),
                      pack(near_coord(600), near_coord(600), near_coord(600)));
      else
        load_triangle(REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}),
                      REG_W'({$urandom, $urandom}), REG_W'({$urandom, $urandom}));
      random_points(80, k % 2 == 0 ? 800 : 20000);
      drain();
    end

    $display("Covered %0d points over 11 triangles: %0d singular, %0d outside results.",
             sb.points_seen, sb.singular_seen, sb.outside_seen);
    $display("Result beats checked: %0d, errors: %0d", sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("triangle_edge_classify verification clean");
    end else begin
      $display("triangle_edge_classify verification failed");
    end
    $finish;
  end

endmodule
